// ===== src/slip_frame_encoder_crc16_macros.svh =====
// Assertion macros shared by the SLIP frame encoder RTL.
`ifndef SLIP_FRAME_ENCODER_CRC16_MACROS_SVH
`define SLIP_FRAME_ENCODER_CRC16_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define SFEC_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition in one cycle is followed by another in the next.
`define SFEC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SFEC_ASSERT(lbl, ck, rst_n, prop, msg)
`define SFEC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/sfec_pkg.sv =====
// Types, constants, microprogram and CRC function of the SLIP frame encoder.
`default_nettype none
package sfec_pkg;

	localparam int MAX_ESCAPED_DFLT = 58;

	// Configuration register indexes and reset values
	localparam logic [1:0] REG_END_CODE    = 2'd0;
	localparam logic [1:0] REG_ESCAPE_CODE = 2'd1;
	localparam logic [1:0] REG_ESC_END     = 2'd2;
	localparam logic [1:0] REG_ESC_ESC     = 2'd3;
	localparam logic [7:0] RST_END_CODE    = 8'd192;
	localparam logic [7:0] RST_ESCAPE_CODE = 8'd219;
	localparam logic [7:0] RST_ESC_END     = 8'd220;
	localparam logic [7:0] RST_ESC_ESC     = 8'd221;

	typedef struct packed {
		logic [7:0] end_code;
		logic [7:0] escape_code;
		logic [7:0] escaped_end_code;
		logic [7:0] escaped_escape_code;
	} cfg_t;

	// Microprogram steps
	typedef logic [3:0] step_t;
	localparam step_t ST_IDLE     = 4'd0;
	localparam step_t ST_APP1     = 4'd1;
	localparam step_t ST_APP2     = 4'd2;
	localparam step_t ST_TX_END   = 4'd3;
	localparam step_t ST_TX_LEN   = 4'd4;
	localparam step_t ST_TX_CMD   = 4'd5;
	localparam step_t ST_TX_RD    = 4'd6;
	localparam step_t ST_TX_DAT   = 4'd7;
	localparam step_t ST_TX_CRCL  = 4'd8;
	localparam step_t ST_TX_CRCH  = 4'd9;
	localparam step_t ST_TX_CLOSE = 4'd10;

	// Sequencing: how the step counter moves once a step fires
	typedef enum logic [2:0] {
		SEQ_NEXT,     // step + 1
		SEQ_JUMP,     // target
		SEQ_WAIT_IN,  // on a request: send -> target, append -> step + 1
		SEQ_FIT,      // two-byte escape that fits -> step + 1, else target
		SEQ_IDX       // buffer read out -> target, else step + 1
	} seq_t;

	// Byte loaded into the output register
	typedef enum logic [2:0] {
		EM_NONE, EM_END, EM_LEN, EM_CMD, EM_RAM, EM_CRCL, EM_CRCH
	} emit_t;

	// Buffer write selection
	typedef enum logic [1:0] {
		WR_NONE, WR_FIRST, WR_SECOND
	} wr_t;

	typedef struct packed {
		seq_t  seq;
		step_t target;
		emit_t emit;
		logic  last;
		wr_t   wr;
		logic  rd;
		logic  idx_clr;
		logic  clr_frame;
		logic  take_in;
	} uc_word_t;

	// Sequencer to datapath
	typedef struct packed {
		uc_word_t w;
		logic     fire;
	} ctl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic fit;
		logic two;
		logic idx_end;
		logic out_free;
	} stat_t;

	// Control store
	function automatic uc_word_t ucode(input step_t step);
		uc_word_t w;
		w.seq       = SEQ_NEXT;
		w.target    = ST_IDLE;
		w.emit      = EM_NONE;
		w.last      = 1'b0;
		w.wr        = WR_NONE;
		w.rd        = 1'b0;
		w.idx_clr   = 1'b0;
		w.clr_frame = 1'b0;
		w.take_in   = 1'b0;
		unique case (step)
			ST_IDLE: begin
				w.seq     = SEQ_WAIT_IN;
				w.target  = ST_TX_END;
				w.take_in = 1'b1;
			end
			ST_APP1: begin
				w.seq    = SEQ_FIT;
				w.target = ST_IDLE;
				w.wr     = WR_FIRST;
			end
			ST_APP2: begin
				w.seq    = SEQ_JUMP;
				w.target = ST_IDLE;
				w.wr     = WR_SECOND;
			end
			ST_TX_END: begin
				w.emit    = EM_END;
				w.idx_clr = 1'b1;
			end
			ST_TX_LEN: w.emit = EM_LEN;
			ST_TX_CMD: w.emit = EM_CMD;
			ST_TX_RD: begin
				w.seq    = SEQ_IDX;
				w.target = ST_TX_CRCL;
				w.rd     = 1'b1;
			end
			ST_TX_DAT: begin
				w.seq    = SEQ_JUMP;
				w.target = ST_TX_RD;
				w.emit   = EM_RAM;
			end
			ST_TX_CRCL: w.emit = EM_CRCL;
			ST_TX_CRCH: w.emit = EM_CRCH;
			ST_TX_CLOSE: begin
				w.seq       = SEQ_JUMP;
				w.target    = ST_IDLE;
				w.emit      = EM_END;
				w.last      = 1'b1;
				w.clr_frame = 1'b1;
			end
			default: begin
				w.seq    = SEQ_JUMP;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

	// One byte of reflected CRC-16, polynomial 0x8408
	function automatic logic [15:0] crc_kermit(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] d;
		d = {8'h00, b ^ crc[7:0]};
		d = {8'h00, d[7:0] ^ {d[3:0], 4'h0}};
		return {d[7:0], crc[15:8]} ^ (d >> 4) ^ (d << 3);
	endfunction

endpackage
`default_nettype wire

// ===== src/sfec_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sfec_ram #(
	parameter int W = 8,
	parameter int D = 58
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== src/sfec_seq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
`default_nettype none
module sfec_seq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	input  wire logic           s_tuser,   // [0] op: 0 append, 1 send
	input  wire sfec_pkg::stat_t st,
	output logic                s_tready,
	output sfec_pkg::ctl_t      ctl
);

	sfec_pkg::step_t    step_q;
	sfec_pkg::step_t    step_nxt;
	sfec_pkg::step_t    step_inc;
	sfec_pkg::uc_word_t w;
	logic               fire;

	// Fetch the control word of the current step
	assign w        = sfec_pkg::ucode(step_q);
	assign step_inc = step_q + sfec_pkg::step_t'(1);

	// A request step fires when a request is there, an emit step when its output slot is free; other steps fire at once
	always_comb begin
		if (w.take_in) begin
			fire = s_tvalid;
		end else begin
			fire = (w.emit == sfec_pkg::EM_NONE) || st.out_free;
		end
	end

	// Choose the next step
	always_comb begin
		unique case (w.seq)
			sfec_pkg::SEQ_NEXT:    step_nxt = step_inc;
			sfec_pkg::SEQ_JUMP:    step_nxt = w.target;
			sfec_pkg::SEQ_WAIT_IN: step_nxt = s_tuser ? w.target : step_inc;
			sfec_pkg::SEQ_FIT:     step_nxt = (st.fit && st.two) ? step_inc : w.target;
			sfec_pkg::SEQ_IDX:     step_nxt = st.idx_end ? w.target : step_inc;
			default:               step_nxt = sfec_pkg::ST_IDLE;
		endcase
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= sfec_pkg::ST_IDLE;
		end else if (fire) begin
			step_q <= step_nxt;
		end
	end

	assign s_tready = w.take_in;
	assign ctl.w    = w;
	assign ctl.fire = fire;

endmodule
`default_nettype wire

// ===== src/sfec_dp.sv =====
// Datapath: escape buffer, CRC, counters and the output register.
`default_nettype none
module sfec_dp #(
	parameter int MAX_ESCAPED = sfec_pkg::MAX_ESCAPED_DFLT
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sfec_pkg::ctl_t  ctl,
	input  wire sfec_pkg::cfg_t  cfg,
	input  wire logic [15:0]     s_tdata,  // [7:0] payload_byte, [15:8] command_code
	output sfec_pkg::stat_t      st,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [7:0]           m_tdata,  // [7:0] frame_byte
	output logic                 m_tlast,
	output logic                 m_tuser   // [0] overflow
);

	localparam int CW = $clog2(MAX_ESCAPED + 1);
	localparam int AW = $clog2(MAX_ESCAPED);

	logic [7:0]    data_q;
	logic [7:0]    cmd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [15:0]   crc_q;
	logic          drop_q;
	logic          ovalid_q;
	logic [7:0]    obyte_q;
	logic          olast_q;
	logic          oflag_q;

	logic          two;
	logic [1:0]    need;
	logic [CW:0]   fill_sum;
	logic          fit;
	logic          idx_end;
	logic          wr_en;
	logic [7:0]    wr_byte;
	logic          rd_en;
	logic [7:0]    rd_byte;
	logic [7:0]    emit_byte;
	logic          out_free;
	logic          do_emit;

	// Escape decision and room check
	assign two      = (data_q == cfg.end_code) || (data_q == cfg.escape_code);
	assign need     = two ? 2'd2 : 2'd1;
	assign fill_sum = {1'b0, count_q} + {{(CW - 1){1'b0}}, need};
	assign fit      = fill_sum <= (CW + 1)'(MAX_ESCAPED);
	assign idx_end  = idx_q == count_q;
	assign out_free = !ovalid_q || m_tready;

	// Select the buffered byte; the delimiter rule wins over the escape rule
	always_comb begin
		wr_byte = data_q;
		if (ctl.w.wr == sfec_pkg::WR_FIRST) begin
			wr_byte = two ? cfg.escape_code : data_q;
		end else if (data_q == cfg.end_code) begin
			wr_byte = cfg.escaped_end_code;
		end else begin
			wr_byte = cfg.escaped_escape_code;
		end
	end

	assign wr_en = ctl.fire && (((ctl.w.wr == sfec_pkg::WR_FIRST) && fit)
		|| (ctl.w.wr == sfec_pkg::WR_SECOND));
	assign rd_en = ctl.fire && ctl.w.rd && !idx_end;

	sfec_ram #(
		.W (8),
		.D (MAX_ESCAPED)
	) u_buf (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (wr_byte),
		.re    (rd_en),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_byte)
	);

	// Latch the request fields
	always_ff @(posedge clk) begin
		if (ctl.fire && ctl.w.take_in) begin
			data_q <= s_tdata[7:0];
			cmd_q  <= s_tdata[15:8];
		end
	end

	// Frame state: fill count, CRC, drop flag, read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= '0;
			drop_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (ctl.fire && ctl.w.clr_frame) begin
				count_q <= '0;
				crc_q   <= '0;
				drop_q  <= 1'b0;
			end else if (wr_en) begin
				count_q <= count_q + CW'(1);
				crc_q   <= sfec_pkg::crc_kermit(crc_q, wr_byte);
			end else if (ctl.fire && (ctl.w.wr == sfec_pkg::WR_FIRST)) begin
				drop_q <= 1'b1;
			end
			if (ctl.fire && ctl.w.idx_clr) begin
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// Pick the outgoing byte
	always_comb begin
		unique case (ctl.w.emit)
			sfec_pkg::EM_END:  emit_byte = cfg.end_code;
			sfec_pkg::EM_LEN:  emit_byte = 8'(count_q) + 8'd1;
			sfec_pkg::EM_CMD:  emit_byte = cmd_q;
			sfec_pkg::EM_RAM:  emit_byte = rd_byte;
			sfec_pkg::EM_CRCL: emit_byte = crc_q[7:0];
			sfec_pkg::EM_CRCH: emit_byte = crc_q[15:8];
			default:           emit_byte = 8'h00;
		endcase
	end

	assign do_emit = ctl.fire && (ctl.w.emit != sfec_pkg::EM_NONE);

	// Output register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (do_emit) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			obyte_q <= emit_byte;
			olast_q <= ctl.w.last;
			oflag_q <= drop_q;
		end
	end

	assign st.fit      = fit;
	assign st.two      = two;
	assign st.idx_end  = idx_end;
	assign st.out_free = out_free;

	assign m_tvalid = ovalid_q;
	assign m_tdata  = obyte_q;
	assign m_tlast  = olast_q;
	assign m_tuser  = oflag_q;

endmodule
`default_nettype wire

// ===== src/slip_frame_encoder_crc16.sv =====
// SLIP frame encoder with CRC-16/Kermit: top level.
// Input stream s_*: one request per item. s_tuser is the op: 0 appends
//   s_tdata[7:0] as a payload byte, 1 closes the frame with s_tdata[15:8]
//   as its command byte.
// Output stream m_*: one frame byte per transfer, in the order END, length,
//   command, escaped payload, CRC low, CRC high, END; m_tlast marks the
//   closing END and m_tuser flags a frame that lost payload bytes.
// APB port: four 8-bit registers (delimiter, escape, escaped delimiter,
//   escaped escape) at byte addresses 0, 4, 8 and 12; write only when idle.
// Sequencing: a microcoded sequencer runs one step per cycle while no step
//   waits for a request or a free output slot. An append runs a write step,
//   plus a second one when an escaped pair is stored. A send emits END,
//   length and command, then a read step and an emit step per buffered byte
//   on the buffer RAM's registered read port, then the CRC bytes and END;
//   header and trailer bytes go out one per cycle while m_tready stays high.
// A new request is taken only when the sequencer is back at its idle step,
//   while the last frame byte may still sit in the output register.
// When m_tready is low and the output register is full, the sequencer holds on its current emit step.
// Reset empties the buffer, clears CRC and drop flag, and loads the
//   standard SLIP codes into the registers.
`default_nettype none
`include "slip_frame_encoder_crc16_macros.svh"
module slip_frame_encoder_crc16 #(
	parameter int MAX_ESCAPED = sfec_pkg::MAX_ESCAPED_DFLT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [7:0] payload_byte, [15:8] command_code
	input  wire logic        s_tuser,   // [0] op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] frame_byte
	output logic             m_tlast,   // last_byte
	output logic             m_tuser,   // [0] overflow
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	sfec_pkg::cfg_t  cfg_q;
	sfec_pkg::ctl_t  ctl;
	sfec_pkg::stat_t st;
	logic            cfg_wr;
	logic [7:0]      rd_reg;
	logic            emit_fire;
	logic            close_fire;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.end_code            <= sfec_pkg::RST_END_CODE;
			cfg_q.escape_code         <= sfec_pkg::RST_ESCAPE_CODE;
			cfg_q.escaped_end_code    <= sfec_pkg::RST_ESC_END;
			cfg_q.escaped_escape_code <= sfec_pkg::RST_ESC_ESC;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				sfec_pkg::REG_END_CODE:    cfg_q.end_code            <= pwdata[7:0];
				sfec_pkg::REG_ESCAPE_CODE: cfg_q.escape_code         <= pwdata[7:0];
				sfec_pkg::REG_ESC_END:     cfg_q.escaped_end_code    <= pwdata[7:0];
				sfec_pkg::REG_ESC_ESC:     cfg_q.escaped_escape_code <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register read-back
	always_comb begin
		unique case (paddr[3:2])
			sfec_pkg::REG_END_CODE:    rd_reg = cfg_q.end_code;
			sfec_pkg::REG_ESCAPE_CODE: rd_reg = cfg_q.escape_code;
			sfec_pkg::REG_ESC_END:     rd_reg = cfg_q.escaped_end_code;
			sfec_pkg::REG_ESC_ESC:     rd_reg = cfg_q.escaped_escape_code;
			default:                   rd_reg = 8'h00;
		endcase
	end
	assign prdata = {24'h000000, rd_reg};

	sfec_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.st       (st),
		.s_tready (s_tready),
		.ctl      (ctl)
	);

	sfec_dp #(
		.MAX_ESCAPED (MAX_ESCAPED)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cfg      (cfg_q),
		.s_tdata  (s_tdata),
		.st       (st),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// Steps that load the output register, and the closing step
	assign emit_fire  = ctl.fire && (ctl.w.emit != sfec_pkg::EM_NONE);
	assign close_fire = ctl.fire && ctl.w.last;

	// A taken request always moves the sequencer off its idle step
	`SFEC_ASSERT_NEXT(a_leave_idle, clk, arst_n, s_tvalid && s_tready, !s_tready, "stuck idle")
	// The closing step puts a last-marked byte in the output register
	`SFEC_ASSERT_NEXT(a_close_last, clk, arst_n, close_fire, m_tvalid && m_tlast, "no closing byte")
	// An emit never overwrites a byte the receiver has not taken
	`SFEC_ASSERT(a_no_overrun, clk, arst_n, emit_fire |-> st.out_free, "output register overrun")

endmodule
`default_nettype wire

// ===== tb/slip_frame_encoder_crc16_check.sv =====
// Scoreboard for the SLIP frame encoder: tracks the codes, predicts each frame, compares bytes.
`timescale 1ns / 1ps
module slip_frame_encoder_crc16_check #(
	parameter logic OP_SEND = 1'b1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] payload_byte, [15:8] command_code
	input  logic        s_tuser,   // [0] op
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [7:0] frame_byte
	input  logic        m_tlast,
	input  logic        m_tuser,   // [0] overflow
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          pending,
	output int          bytes_checked,
	output int          lossy_frames
);

	localparam int          DEPTH      = sfec_pkg::MAX_ESCAPED_DFLT;
	localparam logic [15:0] CRC_POLY   = 16'h8408;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
		logic       overflow;
	} frame_out_t;

	logic [7:0]  end_code;
	logic [7:0]  escape_code;
	logic [7:0]  esc_end;
	logic [7:0]  esc_esc;
	logic [7:0]  escaped_bytes [$];
	logic [15:0] crc_acc;
	logic        dropped;
	frame_out_t  frame_bytes_due [$];
	frame_out_t  seen;

	// Reflected CRC-16, one bit at a time
	function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// Hold one escaped byte in the frame buffer if there is room
	task buffer_byte(input logic [7:0] b);
		if (escaped_bytes.size() < DEPTH) begin
			escaped_bytes = {escaped_bytes, b};
			crc_acc = crc16_fold(crc_acc, b);
		end
	endtask

	task queue_byte(input logic [7:0] b, input logic last);
		frame_out_t fb;
		fb.frame_byte = b;
		fb.last_byte  = last;
		fb.overflow   = dropped;
		frame_bytes_due = {frame_bytes_due, fb};
	endtask

	// Apply one request: escape and buffer a payload byte, or close the frame
	task encode_request(input logic op, input logic [7:0] pay, input logic [7:0] cmd);
		int need;
		if (op != OP_SEND) begin
			need = (pay == end_code || pay == escape_code) ? 2 : 1;
			if (escaped_bytes.size() + need > DEPTH)
				dropped = 1'b1;
			else if (pay == end_code) begin
				buffer_byte(escape_code);
				buffer_byte(esc_end);
			end else if (pay == escape_code) begin
				buffer_byte(escape_code);
				buffer_byte(esc_esc);
			end else
				buffer_byte(pay);
		end else begin
			queue_byte(end_code, 1'b0);
			queue_byte(8'(escaped_bytes.size() + 1), 1'b0);
			queue_byte(cmd, 1'b0);
			foreach (escaped_bytes[i])
				queue_byte(escaped_bytes[i], 1'b0);
			queue_byte(crc_acc[7:0], 1'b0);
			queue_byte(crc_acc[15:8], 1'b0);
			queue_byte(end_code, 1'b1);
			if (dropped)
				lossy_frames++;
			escaped_bytes.delete();
			crc_acc = '0;
			dropped = 1'b0;
		end
	endtask

	task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("%0t: %s mismatch, got %02h, expected %02h", $time, what, got, want);
		mismatches++;
	endtask

	// Watch the three ports; compare outgoing bytes before booking new requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_code    = sfec_pkg::RST_END_CODE;
			escape_code = sfec_pkg::RST_ESCAPE_CODE;
			esc_end     = sfec_pkg::RST_ESC_END;
			esc_esc     = sfec_pkg::RST_ESC_ESC;
			escaped_bytes.delete();
			frame_bytes_due.delete();
			crc_acc = '0;
			dropped = 1'b0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					sfec_pkg::REG_END_CODE:    end_code    = pwdata[7:0];
					sfec_pkg::REG_ESCAPE_CODE: escape_code = pwdata[7:0];
					sfec_pkg::REG_ESC_END:     esc_end     = pwdata[7:0];
					sfec_pkg::REG_ESC_ESC:     esc_esc     = pwdata[7:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				bytes_checked++;
				if (frame_bytes_due.size() == 0)
					report_mismatch("unrequested frame byte", m_tdata, 8'h00);
				else begin
					seen = frame_bytes_due.pop_front();
					if (m_tdata !== seen.frame_byte)
						report_mismatch("frame_byte", m_tdata, seen.frame_byte);
					if (m_tlast !== seen.last_byte)
						report_mismatch("last_byte", 8'(m_tlast), 8'(seen.last_byte));
					if (m_tuser !== seen.overflow)
						report_mismatch("overflow", 8'(m_tuser), 8'(seen.overflow));
				end
			end
			if (s_tvalid && s_tready)
				encode_request(s_tuser, s_tdata[7:0], s_tdata[15:8]);
			pending <= frame_bytes_due.size();
		end
	end

endmodule

// ===== tb/slip_frame_encoder_crc16_test.sv =====
// Stimulus, flow control and verdict for the SLIP frame encoder testbench.
`timescale 1ns / 1ps
module slip_frame_encoder_crc16_test;

	localparam logic OP_APPEND   = 1'b0;
	localparam logic OP_SEND     = 1'b1;
	localparam int   HOLD_CYCLES = 300;
	localparam int   STUCK_LIMIT = 4000;
	localparam int   SETTLE      = 12;
	localparam int   PHASE_ITEMS = 90;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;   // [7:0] payload_byte, [15:8] command_code
	logic        s_tuser  = 1'b0; // [0] op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [7:0] frame_byte
	logic        m_tlast;
	logic        m_tuser;         // [0] overflow
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	int         mismatches;
	int         pending;
	int         bytes_checked;
	int         lossy_frames;
	bit         calm      = 1'b0;
	bit         hold_req  = 1'b0;
	bit         hold_done = 1'b0;
	logic [7:0] codes [4];
	int         requests  = 0;
	int         frames    = 0;
	int         settings  = 1;
	int         stuck     = 0;

	slip_frame_encoder_crc16 uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	slip_frame_encoder_crc16_check #(.OP_SEND(OP_SEND)) chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.mismatches(mismatches), .pending(pending), .bytes_checked(bytes_checked),
		.lossy_frames(lossy_frames)
	);

	always #6 clk = ~clk;

	// Receiver: random back-pressure, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				m_tready <= 1'b1;
			end else
				m_tready <= calm || ($urandom_range(0, 99) >= 12);
		end
	end

	// Drop the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			stuck <= 0;
		else if (stuck >= STUCK_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, stuck);
			$display("CHECK FAILED");
			$finish;
		end else
			stuck <= stuck + 1;
	end

	task automatic offer_request(input logic op, input logic [7:0] pay, input logic [7:0] cmd);
		if (!calm && $urandom_range(0, 99) < 12) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {cmd, pay};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		requests++;
		if (op == OP_SEND)
			frames++;
	endtask

	// Setup cycle, access cycle, then the bus is released
	task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'h000000, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_codes(input logic [7:0] e, input logic [7:0] x,
			input logic [7:0] xe, input logic [7:0] xx);
		apb_write(sfec_pkg::REG_END_CODE, e);
		apb_write(sfec_pkg::REG_ESCAPE_CODE, x);
		apb_write(sfec_pkg::REG_ESC_END, xe);
		apb_write(sfec_pkg::REG_ESC_ESC, xx);
		codes[sfec_pkg::REG_END_CODE]    = e;
		codes[sfec_pkg::REG_ESCAPE_CODE] = x;
		codes[sfec_pkg::REG_ESC_END]     = xe;
		codes[sfec_pkg::REG_ESC_ESC]     = xx;
		settings++;
	endtask

	// Stop offering and let every frame and any append in flight finish
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Mostly short frames, some long enough to overflow the buffer
	task automatic random_frame();
		int         len;
		int         pick;
		logic [7:0] pay;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			len = $urandom_range(0, 12);
		else if (pick < 90)
			len = $urandom_range(13, 30);
		else
			len = $urandom_range(29, 64);
		for (int k = 0; k < len; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 15)
				pay = codes[sfec_pkg::REG_END_CODE];
			else if (pick < 30)
				pay = codes[sfec_pkg::REG_ESCAPE_CODE];
			else
				pay = 8'($urandom_range(0, 255));
			offer_request(OP_APPEND, pay, 8'($urandom_range(0, 255)));
		end
		offer_request(OP_SEND, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int phase;
		int base;
		codes[sfec_pkg::REG_END_CODE]    = sfec_pkg::RST_END_CODE;
		codes[sfec_pkg::REG_ESCAPE_CODE] = sfec_pkg::RST_ESCAPE_CODE;
		codes[sfec_pkg::REG_ESC_END]     = sfec_pkg::RST_ESC_END;
		codes[sfec_pkg::REG_ESC_ESC]     = sfec_pkg::RST_ESC_ESC;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes, both escapes and plain look-alikes under the reset codes
		offer_request(OP_APPEND, 8'h00, 8'hFF);
		offer_request(OP_APPEND, 8'hFF, 8'h00);
		offer_request(OP_APPEND, sfec_pkg::RST_END_CODE, 8'h5A);
		offer_request(OP_APPEND, sfec_pkg::RST_ESCAPE_CODE, 8'hA5);
		offer_request(OP_APPEND, sfec_pkg::RST_ESC_END, 8'h00);
		offer_request(OP_APPEND, sfec_pkg::RST_ESC_ESC, 8'hFF);
		offer_request(OP_SEND, 8'hFF, 8'hFF);
		// Empty frame
		offer_request(OP_SEND, 8'h00, 8'h00);
		// Fill the buffer: a pair that no longer fits is dropped, a single still goes in
		repeat (28) offer_request(OP_APPEND, sfec_pkg::RST_END_CODE, 8'h00);
		offer_request(OP_APPEND, 8'h55, 8'h00);
		offer_request(OP_APPEND, sfec_pkg::RST_ESCAPE_CODE, 8'h00);
		offer_request(OP_APPEND, 8'hAA, 8'h00);
		offer_request(OP_APPEND, 8'h01, 8'h00);
		offer_request(OP_SEND, 8'h00, 8'h3C);
		wait_drained();

		// Random frames under several code settings
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: load_codes(8'h00, 8'hFF, 8'h00, 8'hFF);
				1: load_codes(8'hFF, 8'h00, 8'hFF, 8'h00);
				2: load_codes(8'h7E, 8'h7E, 8'h5E, 8'h5D);
				3: load_codes(sfec_pkg::RST_END_CODE, sfec_pkg::RST_ESCAPE_CODE,
					sfec_pkg::RST_ESC_END, sfec_pkg::RST_ESC_ESC);
				default: load_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			endcase
			calm = (phase == 2);
			// Delimiter equal to escape: the delimiter rule wins
			if (phase == 2) begin
				offer_request(OP_APPEND, 8'h7E, 8'h00);
				offer_request(OP_APPEND, 8'h5E, 8'h00);
				offer_request(OP_SEND, 8'h00, 8'h42);
			end
			base = requests;
			while (requests - base < PHASE_ITEMS) begin
				if (phase == 1 && requests - base > 20)
					hold_req = 1'b1;
				random_frame();
			end
			wait_drained();
		end

		$display("Covered %0d requests in %0d frames under %0d code settings,",
			requests, frames, settings);
		$display("%0d frame bytes compared, %0d frames carried the drop flag.",
			bytes_checked, lossy_frames);
		if (mismatches == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/sfec_pkg.sv
src/sfec_ram.sv
src/sfec_seq.sv
src/sfec_dp.sv
src/slip_frame_encoder_crc16.sv
tb/slip_frame_encoder_crc16_check.sv
tb/slip_frame_encoder_crc16_test.sv
